>>> rtl/quoted_text_tokenizer_core_macros.svh
// ----------------------------------------------------------------------------
// quoted text tokenizer assertion macros
// shared property forms for the tokenizer core checks
// ----------------------------------------------------------------------------
`ifndef QUOTED_TEXT_TOKENIZER_CORE_MACROS_SVH
`define QUOTED_TEXT_TOKENIZER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle, outside reset
`define QTT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer check failed: implication");

// condition must never hold, outside reset
`define QTT_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("tokenizer check failed: forbidden condition");

`endif

>>> rtl/qtt_pkg.sv
// ----------------------------------------------------------------------------
// qtt_pkg
// payload types and character codes for the quoted text tokenizer
// ----------------------------------------------------------------------------
package qtt_pkg;

   // input transfer: one text byte and the per-token length limit
   typedef struct packed {
      logic [7:0] in_char;
      logic [8:0] token_limit;
   } qtt_req_type;

   // result transfer
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_char;
      logic       last;
   } qtt_rsp_type;

   // result kinds
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_TEXT = 2'd2;

   // scan modes
   localparam logic [1:0] MODE_SKIP  = 2'd0;
   localparam logic [1:0] MODE_BARE  = 2'd1;
   localparam logic [1:0] MODE_QUOTE = 2'd2;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_OPEN  = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // results one text byte can cause
   localparam int unsigned MAX_RESULTS = 3;

endpackage

>>> rtl/quoted_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// quoted_text_tokenizer_core
// streaming tokenizer for text with bare tokens, quoted tokens and braces
// ----------------------------------------------------------------------------
// usage
//   req channel: one text byte per transfer (req_data.in_char) with the
//     per-token character limit (req_data.token_limit); byte zero ends the text
//   rsp channel: token characters, end-of-token and end-of-text markers;
//     rsp_data.last flags the final result caused by one input byte
// latency and throughput
//   results of a byte appear on rsp in the cycle after its transfer
//   one byte per cycle while each byte causes at most one result and rsp_stall
//     is low; a byte that causes two or three results holds req while its result
//     group drains, one result per cycle from the group register while rsp_stall is low
//   bytes causing no result (separators between tokens, an opening quote) leave the group empty
// reset
//   synchronous; returns to skipping with an empty group and a zero count
// stalls
//   rsp_stall freezes the result group; req_stall rises until the last result
//   of the group leaves, so nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "quoted_text_tokenizer_core_macros.svh"

module quoted_text_tokenizer_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qtt_pkg::qtt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qtt_pkg::qtt_rsp_type rsp_data
);
   import qtt_pkg::*;

   // tokenizer state
   logic [1:0] mode_ff, mode_in;
   logic [8:0] kept_ff, kept_in;

   // result group: slot 0 is always the one on the rsp port
   qtt_rsp_type grp_ff [MAX_RESULTS];
   qtt_rsp_type grp_in [MAX_RESULTS];
   logic [1:0]  left_ff, left_in;

   logic req_take;
   logic rsp_take;

   // decode of the incoming byte
   logic [7:0] c;
   logic       is_brace;
   logic       is_sep;
   logic       may_keep;
   logic [1:0] mode_cur;
   logic [1:0] n_res;

   assign rsp_valid = (left_ff != 2'd0);
   assign rsp_data  = grp_ff[0];
   assign rsp_take  = rsp_valid && !rsp_stall;

   // a new byte may enter once the group is empty or its last result leaves now
   assign req_stall = (left_ff > 2'd1) || ((left_ff == 2'd1) && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign c        = req_data.in_char;
   assign is_brace = (c == CH_OPEN) || (c == CH_CLOSE);
   assign is_sep   = (c <= CH_SPACE);
   assign may_keep = (kept_ff < req_data.token_limit);

   // unused mode code behaves as skipping
   assign mode_cur = ((mode_ff == MODE_BARE) || (mode_ff == MODE_QUOTE)) ? mode_ff : MODE_SKIP;

   // single-pass step: results and next state for the byte on req
   always_comb begin
      qtt_rsp_type res_v [MAX_RESULTS];
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_v[i] = '{kind: KIND_END, out_char: CH_NUL, last: 1'b0};
      end
      n_res   = 2'd0;
      mode_in = mode_cur;
      kept_in = kept_ff;

      if (c == CH_NUL) begin
         // end of text closes any open token
         if (mode_cur != MODE_SKIP) begin
            res_v[0].kind = KIND_END;
            res_v[1].kind = KIND_TEXT;
            n_res         = 2'd2;
         end else begin
            res_v[0].kind = KIND_TEXT;
            n_res         = 2'd1;
         end
         mode_in = MODE_SKIP;
         kept_in = '0;
      end else begin
         case (mode_cur)
            MODE_QUOTE: begin
               if (c == CH_QUOTE) begin
                  res_v[0].kind = KIND_END;
                  n_res         = 2'd1;
                  mode_in       = MODE_SKIP;
                  kept_in       = '0;
               end else if (may_keep) begin
                  res_v[0] = '{kind: KIND_CHAR, out_char: c, last: 1'b0};
                  n_res    = 2'd1;
                  kept_in  = kept_ff + 9'd1;
               end
            end
            MODE_BARE: begin
               if (is_sep || is_brace) begin
                  // close the bare token; a brace then stands as its own token
                  res_v[0].kind = KIND_END;
                  mode_in       = MODE_SKIP;
                  kept_in       = '0;
                  if (is_brace) begin
                     res_v[1] = '{kind: KIND_CHAR, out_char: c, last: 1'b0};
                     res_v[2].kind = KIND_END;
                     n_res    = 2'd3;
                  end else begin
                     n_res    = 2'd1;
                  end
               end else if (may_keep) begin
                  res_v[0] = '{kind: KIND_CHAR, out_char: c, last: 1'b0};
                  n_res    = 2'd1;
                  kept_in  = kept_ff + 9'd1;
               end
            end
            default: begin
               kept_in = '0;
               if (is_sep) begin
                  n_res = 2'd0;
               end else if (is_brace) begin
                  res_v[0] = '{kind: KIND_CHAR, out_char: c, last: 1'b0};
                  res_v[1].kind = KIND_END;
                  n_res    = 2'd2;
               end else if (c == CH_QUOTE) begin
                  mode_in = MODE_QUOTE;
               end else begin
                  // first character of a bare token, kept if the limit allows, and then the count becomes one
                  mode_in = MODE_BARE;
                  if (req_data.token_limit != 9'd0) begin
                     res_v[0] = '{kind: KIND_CHAR, out_char: c, last: 1'b0};
                     n_res    = 2'd1;
                     kept_in  = 9'd1;
                  end
               end
            end
         endcase
      end

      // flag the final result of the group
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_v[i].last = (n_res == 2'(i + 1));
      end

      // group register next value: load on a new byte, shift on a taken result
      if (req_take) begin
         grp_in  = res_v;
         left_in = n_res;
      end else if (rsp_take) begin
         grp_in[0] = grp_ff[1];
         grp_in[1] = grp_ff[2];
         grp_in[2] = grp_ff[2];
         left_in   = left_ff - 2'd1;
      end else begin
         grp_in  = grp_ff;
         left_in = left_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
         kept_ff <= '0;
         left_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
         if (req_take) begin
            mode_ff <= mode_in;
            kept_ff <= kept_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   // checks
   // no byte enters while more than the final result of a group is pending
   `QTT_ASSERT_NEVER(a_no_overrun, req_take && (left_ff > 2'd1))
   // the last flag marks exactly the final pending result
   `QTT_ASSERT_IMP(a_last_flag, rsp_valid, rsp_data.last == (left_ff == 2'd1))
   // markers carry a zero character
   `QTT_ASSERT_IMP(a_marker_char, rsp_valid && (rsp_data.kind != KIND_CHAR),
                   rsp_data.out_char == CH_NUL)
   // end of text leaves the scanner skipping with a cleared count
   `QTT_ASSERT_IMP(a_text_resets, rsp_valid && (rsp_data.kind == KIND_TEXT),
                   (mode_ff == MODE_SKIP) && (kept_ff == 9'd0))

endmodule
